@@ rtl/spot_pkg.sv @@
// Shared constants and types for the script push-operation tokenizer.
package spot_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned LCNT_W   = 3;
    localparam int unsigned SHIFT_W  = 2;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 16;
    localparam int unsigned M_USER_W = 3;

    localparam logic [BYTE_W-1:0] OP_0          = 8'h00;
    localparam logic [BYTE_W-1:0] OP_PUSH_LEN8  = 8'h4C;
    localparam logic [BYTE_W-1:0] OP_PUSH_LEN16 = 8'h4D;
    localparam logic [BYTE_W-1:0] OP_PUSH_LEN32 = 8'h4E;

    localparam logic [LCNT_W-1:0] LEN_BYTES_PD1 = 3'd1;
    localparam logic [LCNT_W-1:0] LEN_BYTES_PD2 = 3'd2;
    localparam logic [LCNT_W-1:0] LEN_BYTES_PD4 = 3'd4;

    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_PUSH    = 2'd1,
        KIND_LENGTH  = 2'd2,
        KIND_OPERAND = 2'd3
    } kind_t;

endpackage

@@ rtl/script_push_op_tokenizer_top.sv @@
// Script push-operation tokenizer: tags each script byte by its role in an operation.
//
// Usage:
//   The slave channel takes one script byte per word in s_axis_tdata[7:0];
//   s_axis_tlast marks the final byte of a script. The master channel gives
//   one word per input byte: m_axis_tdata holds the opcode of the operation
//   the byte belongs to (bits 7:0) and the byte itself (bits 15:8);
//   m_axis_tuser holds the byte kind (bits 1:0: plain opcode, push opcode,
//   length byte, operand byte) and the truncated flag (bit 2); m_axis_tlast
//   marks the byte that completes an operation.
//   m_axis_tvalid rises in the cycle after a byte is accepted. Throughput is one
//   byte per cycle while the receiver keeps up: the parse state and the result
//   register are updated in the cycle the byte is taken, so the longest
//   recurrence is the 32-bit operand countdown.
//   When the receiver stalls, the result register holds its word and
//   s_axis_tready drops until it is taken; a new byte is accepted in the same
//   cycle that the waiting word leaves.
//   Reset clears the output valid and returns the parser to expecting an
//   opcode. After a final byte the parser also returns to expecting an
//   opcode, so the next byte starts a new script.
module script_push_op_tokenizer_top
    import spot_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [7:0] script_byte
    input  logic                s_axis_tlast,   // last_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // [7:0] opcode, [15:8] data_byte
    output logic [M_USER_W-1:0] m_axis_tuser,   // [1:0] byte_kind, [2] truncated
    output logic                m_axis_tlast    // op_end
);

    typedef enum logic [1:0] {
        PH_OPCODE  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_OPERAND = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LCNT_W-1:0]   len_left_reg, len_left_next;
    logic [LEN_W-1:0]    asm_len_reg, asm_len_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [LEN_W-1:0]    opnd_left_reg, opnd_left_next;
    logic [BYTE_W-1:0]   cur_op_reg, cur_op_next;

    logic                m_valid_reg, m_valid_next;
    kind_t               kind_reg, kind_next;
    logic [BYTE_W-1:0]   op_out_reg, data_out_reg;
    logic                end_reg, end_next;
    logic                trunc_reg, trunc_next;

    logic                s_accept;
    logic [BYTE_W-1:0]   in_byte;
    logic [LEN_W-1:0]    len_merged;
    logic [LCNT_W-1:0]   len_left_dec;
    logic [LEN_W-1:0]    opnd_left_dec;

    assign in_byte       = s_axis_tdata[BYTE_W-1:0];
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign len_merged    = asm_len_reg | (LEN_W'(in_byte) << {shift_reg, 3'b000});
    assign len_left_dec  = len_left_reg - LCNT_W'(1);
    assign opnd_left_dec = opnd_left_reg - LEN_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        asm_len_next   = asm_len_reg;
        shift_next     = shift_reg;
        opnd_left_next = opnd_left_reg;
        cur_op_next    = cur_op_reg;
        kind_next      = KIND_PLAIN;
        end_next       = 1'b0;
        trunc_next     = 1'b0;

        case (phase_reg)
            PH_LENGTH: begin
                kind_next     = KIND_LENGTH;
                asm_len_next  = len_merged;
                shift_next    = shift_reg + SHIFT_W'(1);
                len_left_next = len_left_dec;
                if (len_left_dec == '0) begin
                    if (len_merged == '0) begin
                        // A zero-length push ends on its last length byte.
                        end_next   = 1'b1;
                        phase_next = PH_OPCODE;
                    end else begin
                        opnd_left_next = len_merged;
                        phase_next     = PH_OPERAND;
                    end
                end
            end
            PH_OPERAND: begin
                kind_next      = KIND_OPERAND;
                opnd_left_next = opnd_left_dec;
                if (opnd_left_dec == '0) begin
                    end_next   = 1'b1;
                    phase_next = PH_OPCODE;
                end
            end
            default: begin
                cur_op_next = in_byte;
                phase_next  = PH_OPCODE;
                if (in_byte > OP_PUSH_LEN32) begin
                    kind_next = KIND_PLAIN;
                    end_next  = 1'b1;
                end else begin
                    kind_next = KIND_PUSH;
                    if (in_byte == OP_0) begin
                        end_next = 1'b1;
                    end else if (in_byte < OP_PUSH_LEN8) begin
                        opnd_left_next = LEN_W'(in_byte);
                        phase_next     = PH_OPERAND;
                    end else begin
                        case (in_byte)
                            OP_PUSH_LEN8:  len_left_next = LEN_BYTES_PD1;
                            OP_PUSH_LEN16: len_left_next = LEN_BYTES_PD2;
                            default:       len_left_next = LEN_BYTES_PD4;
                        endcase
                        asm_len_next = '0;
                        shift_next   = '0;
                        phase_next   = PH_LENGTH;
                    end
                end
            end
        endcase

        if (s_axis_tlast) begin
            // The script ends here; an unfinished operation is flagged.
            if (phase_next != PH_OPCODE) begin
                trunc_next = 1'b1;
                end_next   = 1'b0;
            end
            phase_next     = PH_OPCODE;
            len_left_next  = '0;
            asm_len_next   = '0;
            shift_next     = '0;
            opnd_left_next = '0;
        end

        m_valid_next = m_valid_reg && !m_axis_tready;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_OPCODE;
            len_left_reg  <= '0;
            asm_len_reg   <= '0;
            shift_reg     <= '0;
            opnd_left_reg <= '0;
            cur_op_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                phase_reg     <= phase_next;
                len_left_reg  <= len_left_next;
                asm_len_reg   <= asm_len_next;
                shift_reg     <= shift_next;
                opnd_left_reg <= opnd_left_next;
                cur_op_reg    <= cur_op_next;
                kind_reg      <= kind_next;
                op_out_reg    <= cur_op_next;
                data_out_reg  <= in_byte;
                end_reg       <= end_next;
                trunc_reg     <= trunc_next;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {data_out_reg, op_out_reg};
    assign m_axis_tuser  = {trunc_reg, kind_reg};
    assign m_axis_tlast  = end_reg;

    a_reset_phase: assert property (@(posedge aclk)
        !aresetn |=> phase_reg == PH_OPCODE)
        else $error("parser not idle after reset");

    a_trunc_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && trunc_reg |-> !end_reg)
        else $error("truncated word also marks operation end");

    a_plain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_PLAIN |-> end_reg && !trunc_reg)
        else $error("plain opcode does not complete its operation");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_axis_tlast |=> phase_reg == PH_OPCODE && opnd_left_reg == '0)
        else $error("parser not cleared after final byte");

    a_operand_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_OPERAND |-> opnd_left_reg != '0)
        else $error("operand phase with no bytes left");

endmodule
